// ----- rtl/hcfc_pkg.sv -----
package hcfc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  opcode_t;
  typedef logic [22:0] wait_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC     = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_STREAM   = 1'b1;

  localparam opcode_t OP_NONE      = 4'd0;
  localparam opcode_t OP_SET_INTEG = 4'd3;
  localparam opcode_t OP_SET_AVG   = 4'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // spectrometer frame headers
  localparam byte_t HDR_INTEG = 8'h69;
  localparam byte_t HDR_AVG   = 8'h41;

  localparam logic [31:0] INTEG_RESET = 32'd500;
  localparam logic [15:0] AVG_RESET   = 16'd20;

  // ceil(2^38 / 1000): floor(x * RECIP_1000 >> 38) == x / 1000 for any 32-bit x
  localparam logic [31:0] RECIP_1000 = 32'd274877907;
  localparam int          RECIP_SHIFT = 38;

  localparam int NUM_TPL = 11;

  localparam byte_t TPL_BYTES [NUM_TPL][8] = '{
    '{8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h3C},
    '{8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h78},
    '{8'h01, 8'h03, 8'h00, 8'h00, 8'h01, 8'hF4, 8'hDD, 8'h45},
    '{8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A, 8'hF0},
    '{8'h01, 8'h05, 8'h00, 8'h32, 8'h00, 8'h00, 8'h05, 8'h6C},
    '{8'h01, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'hCA, 8'h89},
    '{8'h01, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A, 8'hB4},
    '{8'h01, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0B, 8'hE0},
    '{8'h01, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'hCB, 8'hDD},
    '{8'h01, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'hCB, 8'h99},
    '{8'h01, 8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0B, 8'hA4}
  };

  // number of leading bytes that must match
  localparam logic [3:0] TPL_LEN [NUM_TPL] = '{
    4'd8, 4'd8, 4'd2, 4'd8, 4'd2, 4'd4, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
  };

  // one byte of CRC-16/MODBUS, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input byte_t b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/hcfc_if.sv -----
interface hcfc_in_if;
  logic              valid;
  logic              ready;
  hcfc_pkg::byte_t   data_byte;
  logic              frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface hcfc_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  hcfc_pkg::status_e status;
  hcfc_pkg::opcode_t opcode;
  hcfc_pkg::byte_t   out_byte;
  hcfc_pkg::wait_t   dwell_time;
  logic              last_of_run;

  modport source (output valid, output kind, output status, output opcode,
                  output out_byte, output dwell_time, output last_of_run, input ready);
  modport sink   (input valid, input kind, input status, input opcode,
                  input out_byte, input dwell_time, input last_of_run, output ready);
endinterface

// ----- rtl/host_command_frame_checker_core.sv -----
// Host command frame checker. Bytes of 8-byte host command frames come in on
// host_i, one request per byte; frame_last marks the end of a frame. Bytes past
// the eighth are dropped, missing bytes read as zero. At frame end the frame is
// matched against eleven fixed command templates in order, its bytes 6/7 are
// checked against the CRC-16/MODBUS of bytes 0..5, and result_o delivers one
// decision request (status, opcode, wait time). An accepted set-integration or
// set-average command updates the stored value and is followed by 7 or 5
// spectrometer frame bytes carrying a freshly computed CRC. dwell_time is
// (integration * average mod 2^32) / 1000 after any update from this frame.
// After a frame end the checker pads missing bytes of 0..5 into the CRC with zeros,
// tries templates one per cycle (1..11 tried), runs a check step, for a set
// command runs the byte-wide CRC unit over the outgoing frame, then uses the shared
// 32x32 multiplier for the product and then the divide-by-1000 via reciprocal.
// Result requests then go out one per cycle while result_o is ready. host_i is
// not ready from frame end until the last result is taken.
module host_command_frame_checker_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  hcfc_in_if.sink          host_i,
  hcfc_out_if.source       result_o
);
  import hcfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_MATCH, S_CHECK, S_FCRC, S_MUL1, S_MUL2, S_OUT, S_STREAM
  } state_e;

  state_e      state_q, state_d;
  byte_t       store_q [8];
  byte_t       store_d [8];
  logic [3:0]  cnt_q, cnt_d;     // bytes received, 0..8
  logic [15:0] crc_q, crc_d;     // shared CRC register: host check, then outgoing frame
  logic [31:0] integ_q, integ_d;
  logic [15:0] avg_q, avg_d;
  logic [3:0]  idx_q, idx_d;     // template index, then outgoing byte index
  logic [2:0]  ndata_q, ndata_d; // outgoing bytes covered by CRC
  logic [2:0]  rem_q, rem_d;     // stream bytes still to send

  // payload, no reset
  opcode_t     opcode_q, opcode_d;
  status_e     status_q, status_d;
  byte_t       sb_q [7];
  byte_t       sb_d [7];
  logic [31:0] prod_q, prod_d;
  wait_t       wait_q, wait_d;

  logic        tpl_hit;
  logic        crc_ok;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // one template per cycle
  always_comb begin
    tpl_hit = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < TPL_LEN[idx_q] && store_q[j] != TPL_BYTES[idx_q][j]) begin
        tpl_hit = 1'b0;
      end
    end
  end

  assign crc_ok = (store_q[6] == crc_q[15:8]) && (store_q[7] == crc_q[7:0]);

  // shared multiplier: integ*avg, then product*reciprocal
  assign mul_a = (state_q == S_MUL1) ? integ_q : prod_q;
  assign mul_b = (state_q == S_MUL1) ? {16'h0000, avg_q} : RECIP_1000;
  assign mul_p = mul_a * mul_b;

  assign host_i.ready = (state_q == S_IDLE);

  assign result_o.valid       = (state_q == S_OUT) || (state_q == S_STREAM);
  assign result_o.kind        = (state_q == S_STREAM) ? KIND_STREAM : KIND_DECISION;
  assign result_o.status      = (state_q == S_STREAM) ? ST_OK : status_q;
  assign result_o.opcode      = opcode_q;
  assign result_o.out_byte    = (state_q == S_STREAM) ? sb_q[0] : 8'h00;
  assign result_o.dwell_time  = wait_q;
  assign result_o.last_of_run = (state_q == S_STREAM) ? (rem_q == 3'd1) : (rem_q == 3'd0);

  always_comb begin
    state_d  = state_q;
    store_d  = store_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    integ_d  = integ_q;
    avg_d    = avg_q;
    idx_d    = idx_q;
    ndata_d  = ndata_q;
    rem_d    = rem_q;
    opcode_d = opcode_q;
    status_d = status_q;
    sb_d     = sb_q;
    prod_d   = prod_q;
    wait_d   = wait_q;

    unique case (state_q)
      S_IDLE: begin
        if (host_i.valid) begin
          if (cnt_q < 4'd8) begin
            store_d[cnt_q[2:0]] = host_i.data_byte;
            if (cnt_q < 4'd6) begin
              crc_d = crc_feed(crc_q, host_i.data_byte);
            end
            cnt_d = cnt_q + 4'd1;
          end
          if (host_i.frame_last) begin
            state_d = S_PAD;
          end
        end
      end

      // missing bytes count as zero in the CRC
      S_PAD: begin
        if (cnt_q < 4'd6) begin
          crc_d = crc_feed(crc_q, 8'h00);
          cnt_d = cnt_q + 4'd1;
        end else begin
          idx_d   = 4'd0;
          state_d = S_MATCH;
        end
      end

      S_MATCH: begin
        if (tpl_hit) begin
          opcode_d = idx_q + 4'd1;
          state_d  = S_CHECK;
        end else if (idx_q == 4'(NUM_TPL - 1)) begin
          opcode_d = OP_NONE;
          state_d  = S_CHECK;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end

      S_CHECK: begin
        idx_d   = 4'd0;
        crc_d   = CRC_INIT;
        ndata_d = 3'd0;
        rem_d   = 3'd0;
        state_d = S_MUL1;
        if (opcode_q == OP_NONE) begin
          status_d = ST_NOMATCH;
        end else if (crc_ok) begin
          status_d = ST_OK;
          if (opcode_q == OP_SET_INTEG) begin
            sb_d[0] = HDR_INTEG;
            sb_d[1] = store_q[2];
            sb_d[2] = store_q[3];
            sb_d[3] = store_q[4];
            sb_d[4] = store_q[5];
            ndata_d = 3'd5;
            integ_d = {store_q[2], store_q[3], store_q[4], store_q[5]};
            state_d = S_FCRC;
          end else if (opcode_q == OP_SET_AVG) begin
            sb_d[0] = HDR_AVG;
            sb_d[1] = store_q[2];
            sb_d[2] = store_q[3];
            ndata_d = 3'd3;
            avg_d   = {store_q[2], store_q[3]};
            state_d = S_FCRC;
          end
        end else begin
          status_d = ST_CRC;
        end
      end

      // CRC of outgoing frame, one byte per cycle, then append hi/lo
      S_FCRC: begin
        if (idx_q[2:0] == ndata_q) begin
          sb_d[ndata_q]        = crc_q[15:8];
          sb_d[ndata_q + 3'd1] = crc_q[7:0];
          rem_d                = ndata_q + 3'd2;
          state_d              = S_MUL1;
        end else begin
          crc_d = crc_feed(crc_q, sb_q[idx_q[2:0]]);
          idx_d = idx_q + 4'd1;
        end
      end

      S_MUL1: begin
        prod_d  = mul_p[31:0];
        state_d = S_MUL2;
      end

      S_MUL2: begin
        wait_d = mul_p[RECIP_SHIFT + 22:RECIP_SHIFT];
        for (int j = 0; j < 8; j++) begin
          store_d[j] = 8'h00;
        end
        cnt_d   = 4'd0;
        crc_d   = CRC_INIT;
        state_d = S_OUT;
      end

      S_OUT: begin
        if (result_o.ready) begin
          state_d = (rem_q == 3'd0) ? S_IDLE : S_STREAM;
        end
      end

      S_STREAM: begin
        if (result_o.ready) begin
          for (int j = 0; j < 6; j++) begin
            sb_d[j] = sb_q[j + 1];
          end
          rem_d = rem_q - 3'd1;
          if (rem_q == 3'd1) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int j = 0; j < 8; j++) begin
        store_q[j] <= 8'h00;
      end
      cnt_q   <= 4'd0;
      crc_q   <= CRC_INIT;
      integ_q <= INTEG_RESET;
      avg_q   <= AVG_RESET;
      idx_q   <= 4'd0;
      ndata_q <= 3'd0;
      rem_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      store_q <= store_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      integ_q <= integ_d;
      avg_q   <= avg_d;
      idx_q   <= idx_d;
      ndata_q <= ndata_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opcode_q <= opcode_d;
    status_q <= status_d;
    sb_q     <= sb_d;
    prod_q   <= prod_d;
    wait_q   <= wait_d;
  end

endmodule
